@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mmh_pkg.sv @@
// ----------------------------------------------------------------------------
// mmh_pkg
// Types, constants and helpers for the MurmurHash64A stream block.
// ----------------------------------------------------------------------------
package mmh_pkg;

    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUL_LO     = MIX_MUL[31:0];
    localparam logic [31:0] MUL_HI     = MIX_MUL[63:32];
    localparam int unsigned MIX_SHIFT  = 47;
    localparam logic [63:0] SEED_RESET = 64'd104729;
    localparam logic [3:0]  FULL_WORD  = 4'd8;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_WORD,
        S_KMIX,
        S_ACC,
        S_FIN,
        S_EMIT
    } state_t;

    // Partial product being folded into the result
    typedef enum logic [1:0] {
        PH_LL,
        PH_LH,
        PH_HL
    } mul_phase_t;

    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

    // x ^ (x >> 47)
    function automatic logic [63:0] shr_mix(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

    // Clamp a valid-byte count to a full word
    function automatic logic [3:0] clamp_count(input logic [3:0] n);
        return (n > FULL_WORD) ? FULL_WORD : n;
    endfunction

    // Where a word goes once the accumulator is seeded
    function automatic state_t word_route(input logic [3:0] n, input logic last);
        state_t s;
        if (n == FULL_WORD) begin
            s = S_WORD;
        end else if (n != 4'd0) begin
            s = S_ACC;
        end else if (last) begin
            s = S_FIN;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/mmh_mul.sv @@
// ----------------------------------------------------------------------------
// mmh_mul
// Multiplies a 64-bit operand by the mixing constant, modulo 2^64, using one
// 32x32 multiplier in turn (low x low, low x high, high x low).
// ----------------------------------------------------------------------------
module mmh_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  mmh_pkg::mul_req_t req,
    output mmh_pkg::mul_rsp_t rsp
);

    logic [63:0]         op_reg, op_next;
    logic [63:0]         prod_reg, prod_next;
    mmh_pkg::mul_phase_t phase_reg, phase_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [31:0] a_sel;
    logic [31:0] b_sel;
    logic [63:0] part;

    // Select the halves for this phase and form one partial product
    always_comb begin
        a_sel = (phase_reg == mmh_pkg::PH_HL) ? op_reg[63:32] : op_reg[31:0];
        b_sel = (phase_reg == mmh_pkg::PH_LH) ? mmh_pkg::MUL_HI : mmh_pkg::MUL_LO;
        part  = a_sel * b_sel;
    end

    // Advance through the phases, folding cross terms into the upper half
    always_comb begin
        op_next    = op_reg;
        prod_next  = prod_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            op_next    = req.operand;
            phase_next = mmh_pkg::PH_LL;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            case (phase_reg)
                mmh_pkg::PH_LL: begin
                    prod_next  = part;
                    phase_next = mmh_pkg::PH_LH;
                end
                mmh_pkg::PH_LH: begin
                    prod_next[63:32] = prod_reg[63:32] + part[31:0];
                    phase_next       = mmh_pkg::PH_HL;
                end
                mmh_pkg::PH_HL: begin
                    prod_next[63:32] = prod_reg[63:32] + part[31:0];
                    phase_next       = mmh_pkg::PH_LL;
                    busy_next        = 1'b0;
                    done_next        = 1'b1;
                end
                default: begin
                    phase_next = mmh_pkg::PH_LL;
                    busy_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        prod_reg <= prod_next;
        if (!aresetn) begin
            phase_reg <= mmh_pkg::PH_LL;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = prod_reg;

endmodule

@@ hw/rtl/murmur_hash_64a_stream.sv @@
// ----------------------------------------------------------------------------
// murmur_hash_64a_stream: all multiplies run on the shared 32x32 multiplier:
// full word: word, k mix, accumulate; tail word: accumulate; first beat adds
// length, last beat avalanche and hand-off; s_tready is high only when idle.
// Synchronous active-low reset: seed 104729, accumulator cleared, no result.
// ----------------------------------------------------------------------------
module murmur_hash_64a_stream (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,    // hash_seed
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,      // data_word[63:0], valid_bytes[67:64],
                                       // message_length[99:68], zero[103:100]
    input  logic         s_tlast,      // last_item
    input  logic         s_tuser,      // first_item
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata       // hash_value
);

    mmh_pkg::state_t state_reg, state_next;
    logic        go_reg, go_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] k_reg, k_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  nvalid_reg, nvalid_next;
    logic [31:0] len_reg, len_next;
    logic        last_reg, last_next;
    logic        in_msg_reg, in_msg_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;

    mmh_pkg::mul_req_t mul_req;
    mmh_pkg::mul_rsp_t mul_rsp;

    logic        s_accept;
    logic [3:0]  s_nvalid;
    logic [63:0] tail_word;
    logic [63:0] mix_in;
    logic        out_free;

    assign s_tready = (state_reg == mmh_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_nvalid = mmh_pkg::clamp_count(s_tdata[67:64]);
    assign out_free = !m_valid_reg || m_tready;

    // Keep only the valid low bytes of a tail word
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            tail_word[8*i +: 8] = (4'(i) < nvalid_reg) ? word_reg[8*i +: 8] : 8'h00;
        end
        mix_in = (nvalid_reg == mmh_pkg::FULL_WORD) ? k_reg : tail_word;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mmh_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        state_next = mmh_pkg::S_LEN;
                    end else if (in_msg_reg) begin
                        state_next = mmh_pkg::word_route(s_nvalid, s_tlast);
                    end
                end
            end
            mmh_pkg::S_LEN: begin
                if (mul_rsp.done) begin
                    state_next = mmh_pkg::word_route(nvalid_reg, last_reg);
                end
            end
            mmh_pkg::S_WORD: begin
                if (mul_rsp.done) begin
                    state_next = mmh_pkg::S_KMIX;
                end
            end
            mmh_pkg::S_KMIX: begin
                if (mul_rsp.done) begin
                    state_next = mmh_pkg::S_ACC;
                end
            end
            mmh_pkg::S_ACC: begin
                if (mul_rsp.done) begin
                    state_next = last_reg ? mmh_pkg::S_FIN : mmh_pkg::S_IDLE;
                end
            end
            mmh_pkg::S_FIN: begin
                if (mul_rsp.done) begin
                    state_next = mmh_pkg::S_EMIT;
                end
            end
            mmh_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = mmh_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mmh_pkg::S_IDLE;
            end
        endcase
    end

    // Multiplier operand for the current step; the start request is registered and raised on entry
    always_comb begin
        go_next = (state_next != state_reg) &&
                  (state_next inside {mmh_pkg::S_LEN, mmh_pkg::S_WORD, mmh_pkg::S_KMIX,
                                      mmh_pkg::S_ACC, mmh_pkg::S_FIN});
        mul_req.start = go_reg;
        case (state_reg)
            mmh_pkg::S_LEN:  mul_req.operand = {32'd0, len_reg};
            mmh_pkg::S_WORD: mul_req.operand = word_reg;
            mmh_pkg::S_KMIX: mul_req.operand = mmh_pkg::shr_mix(k_reg);
            mmh_pkg::S_ACC:  mul_req.operand = acc_reg ^ mix_in;
            mmh_pkg::S_FIN:  mul_req.operand = mmh_pkg::shr_mix(acc_reg);
            default:         mul_req.operand = 64'd0;
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        seed_next    = seed_reg;
        acc_next     = acc_reg;
        k_next       = k_reg;
        word_next    = word_reg;
        nvalid_next  = nvalid_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        in_msg_next  = in_msg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_we) begin
            seed_next = cfg_wdata;
        end

        // Capture the beat
        if (s_accept) begin
            word_next   = s_tdata[63:0];
            nvalid_next = s_nvalid;
            len_next    = s_tdata[99:68];
            last_next   = s_tlast;
            if (s_tuser) begin
                in_msg_next = 1'b1;
            end
        end

        // Fold in multiplier results
        if (mul_rsp.done) begin
            case (state_reg)
                mmh_pkg::S_LEN:  acc_next = seed_reg ^ mul_rsp.product;
                mmh_pkg::S_WORD: k_next   = mul_rsp.product;
                mmh_pkg::S_KMIX: k_next   = mul_rsp.product;
                mmh_pkg::S_ACC:  acc_next = mul_rsp.product;
                mmh_pkg::S_FIN:  k_next   = mmh_pkg::shr_mix(mul_rsp.product);
                default:         acc_next = acc_reg;
            endcase
        end

        // Drop a taken result, then load a new one
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == mmh_pkg::S_EMIT) && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = k_reg;
            acc_next     = 64'd0;
            in_msg_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        word_reg   <= word_next;
        nvalid_reg <= nvalid_next;
        len_reg    <= len_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= mmh_pkg::S_IDLE;
            go_reg      <= 1'b0;
            seed_reg    <= mmh_pkg::SEED_RESET;
            acc_reg     <= 64'd0;
            in_msg_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            go_reg      <= go_next;
            seed_reg    <= seed_next;
            acc_reg     <= acc_next;
            in_msg_reg  <= in_msg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    mmh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ hw/rtl/mmh_checker.sv @@
// ----------------------------------------------------------------------------
// mmh_checker
// Port-level checks for the MurmurHash64A stream block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmh_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata
);

    // A stalled result stays offered
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")

    // A stalled result keeps its value
    `ASSERT_CLK(a_out_stable, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")

    // An opening beat starts the length multiply, so the block goes busy
    `ASSERT_CLK(a_first_busy, aclk, aresetn, (s_tvalid && s_tready && s_tuser) |=> !s_tready, "ready after a first beat")

    // Reset leaves no result offered
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result offered after reset")

endmodule

bind murmur_hash_64a_stream mmh_checker u_mmh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
